// ===== rtl/core/prp_pkg.sv =====
package prp_pkg;

  // Algorithm constants
  localparam int unsigned FRAGMENT_BYTES = 1500;
  localparam int unsigned HEADER_BYTES   = 48;
  localparam int unsigned MSEC_PER_SEC   = 1000;
  localparam int unsigned RATE_FLOOR     = 1000;
  localparam int unsigned IDLE_WAIT_MS   = 1000;

  // Field widths
  localparam int unsigned SIZE_W    = 15;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned RATE_W    = 17;
  localparam int unsigned IVL_W     = 16;
  localparam int unsigned MSEC_W    = 21;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DL_MAX_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAN_FORCE   = 2'd2;

  // Divider sizing: dividend is (clipped size + header) * 1000
  localparam int unsigned DIV_W  = $clog2((FRAGMENT_BYTES + HEADER_BYTES) * MSEC_PER_SEC + 1);
  localparam int unsigned QEXT_W = (DIV_W > MSEC_W) ? DIV_W : MSEC_W;
  localparam int unsigned RATE_MSEC_MAX = (1 << MSEC_W) - 1;

  // start edge to done strobe, in clock edges
  localparam int unsigned LATENCY = DIV_W + 3;

  // Front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CFG_W-1:0] max_rate;
    logic [CFG_W-1:0] dl_max_rate;
    logic             lan_force;
  } cfg_t;

  // Classified transaction handed from front to back
  typedef struct packed {
    logic              local_client;
    logic              dl;
    logic              active;
    logic [TIME_W-1:0] now;
    logic [IVL_W-1:0]  interval;
    logic [DIV_W-1:0]  dividend;
    logic [RATE_W-1:0] divisor;
  } item_t;

  // One divider pipeline stage
  typedef struct packed {
    logic              local_client;
    logic              dl;
    logic              active;
    logic [TIME_W-1:0] now;
    logic [IVL_W-1:0]  interval;
    logic [RATE_W-1:0] divisor;
    logic [DIV_W-1:0]  num;   // dividend shifting out, quotient shifting in
    logic [RATE_W-1:0] rem;
  } div_stage_t;

endpackage

// ===== rtl/core/prp_front.sv =====
module prp_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [prp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [prp_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [prp_pkg::SIZE_W-1:0]     message_size_i,
  input  logic [prp_pkg::TIME_W-1:0]     current_time_i,
  input  logic [prp_pkg::RATE_W-1:0]     client_rate_i,
  input  logic [prp_pkg::IVL_W-1:0]      snapshot_interval_i,
  input  logic                           downloading_i,
  input  logic                           client_active_i,
  input  logic                           is_loopback_i,
  input  logic                           is_lan_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output prp_pkg::item_t                 item_o
);

  prp_pkg::cfg_t  cfg_q, cfg_d;
  logic           f_valid_q, f_valid_d;
  prp_pkg::item_t f_item_q, f_item_d;

  logic                         take;
  logic [prp_pkg::SIZE_W-1:0]   size_c;
  logic [prp_pkg::RATE_W-1:0]   cap;
  logic [prp_pkg::RATE_W-1:0]   div_r;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        prp_pkg::CFG_MAX_RATE:    cfg_d.max_rate    = cfg_data_i;
        prp_pkg::CFG_DL_MAX_RATE: cfg_d.dl_max_rate = cfg_data_i;
        prp_pkg::CFG_LAN_FORCE:   cfg_d.lan_force   = cfg_data_i[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  assign push_o = f_valid_q && !q_full_i;
  assign busy_o = f_valid_q && q_full_i;
  assign take   = start_i && !busy_o;

  // Classification: local check, size clip, rate cap
  always_comb begin
    size_c = (message_size_i > prp_pkg::SIZE_W'(prp_pkg::FRAGMENT_BYTES)) ?
             prp_pkg::SIZE_W'(prp_pkg::FRAGMENT_BYTES) : message_size_i;

    if (downloading_i) begin
      cap = cfg_q.dl_max_rate;
    end else if (cfg_q.max_rate != '0 &&
                 cfg_q.max_rate < prp_pkg::RATE_W'(prp_pkg::RATE_FLOOR)) begin
      cap = prp_pkg::RATE_W'(prp_pkg::RATE_FLOOR);
    end else begin
      cap = cfg_q.max_rate;
    end

    div_r = (cap != '0 && cap < client_rate_i) ? cap : client_rate_i;
    if (div_r == '0) begin
      div_r = prp_pkg::RATE_W'(1);
    end

    f_item_d.local_client = is_loopback_i || (cfg_q.lan_force && is_lan_i);
    f_item_d.dl           = downloading_i;
    f_item_d.active       = client_active_i;
    f_item_d.now          = current_time_i;
    f_item_d.interval     = snapshot_interval_i;
    f_item_d.dividend     = prp_pkg::DIV_W'(
                              (prp_pkg::DIV_W'(size_c) + prp_pkg::DIV_W'(prp_pkg::HEADER_BYTES))
                              * prp_pkg::DIV_W'(prp_pkg::MSEC_PER_SEC));
    f_item_d.divisor      = div_r;
  end

  assign f_valid_d = take || (f_valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= '0;
      f_valid_q <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      f_item_q <= f_item_d;
    end
  end

  assign item_o = f_item_q;

endmodule

// ===== rtl/core/prp_queue.sv =====
module prp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  prp_pkg::item_t   item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output prp_pkg::item_t   head_o
);

  prp_pkg::item_t              mem_q [prp_pkg::QUEUE_DEPTH];
  logic [prp_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [prp_pkg::QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [prp_pkg::QCNT_W-1:0]  cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign full_o  = (cnt_q == prp_pkg::QCNT_W'(prp_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == prp_pkg::QPTR_W'(prp_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == prp_pkg::QPTR_W'(prp_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/core/prp_back.sv =====
module prp_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  prp_pkg::item_t               head_i,
  output logic                         pop_o,
  output logic                         done_o,
  output logic [prp_pkg::TIME_W-1:0]   next_send_time_o,
  output logic [prp_pkg::MSEC_W-1:0]   rate_msec_o,
  output logic                         rate_delayed_o,
  output logic                         delay_flag_valid_o
);

  localparam int unsigned DW = prp_pkg::DIV_W;
  localparam int unsigned RW = prp_pkg::RATE_W;

  prp_pkg::div_stage_t st_q [DW];
  prp_pkg::div_stage_t st_d [DW];
  prp_pkg::div_stage_t src  [DW];
  logic [DW-1:0]       v_q;

  logic [RW:0]         trial [DW];
  logic [DW-1:0]       ge;

  // Back end never stalls: drain the queue whenever it holds something
  assign pop_o = !q_empty_i;

  // Restoring divider, one quotient bit per stage
  always_comb begin
    src[0].local_client = head_i.local_client;
    src[0].dl           = head_i.dl;
    src[0].active       = head_i.active;
    src[0].now          = head_i.now;
    src[0].interval     = head_i.interval;
    src[0].divisor      = head_i.divisor;
    src[0].num          = head_i.dividend;
    src[0].rem          = '0;
    for (int i = 1; i < DW; i++) begin
      src[i] = st_q[i-1];
    end
    for (int i = 0; i < DW; i++) begin
      trial[i] = {src[i].rem, src[i].num[DW-1]};
      ge[i]    = (trial[i] >= {1'b0, src[i].divisor});
      st_d[i]  = src[i];
      st_d[i].rem = ge[i] ? RW'(trial[i] - {1'b0, src[i].divisor}) : trial[i][RW-1:0];
      st_d[i].num = {src[i].num[DW-2:0], ge[i]};
    end
  end

  // Finish: saturate, interval floor, idle minimum, time add, local-client override
  prp_pkg::div_stage_t         fin;
  logic [prp_pkg::QEXT_W-1:0]  q_ext;
  logic [prp_pkg::MSEC_W-1:0]  quot, delay, offset;
  logic                        ivl_wins;
  logic                        done_d;
  logic [prp_pkg::TIME_W-1:0]  next_d;
  logic [prp_pkg::MSEC_W-1:0]  msec_d;
  logic                        delayed_d, flag_valid_d;

  always_comb begin
    fin   = st_q[DW-1];
    q_ext = prp_pkg::QEXT_W'(fin.num);
    quot  = (q_ext > prp_pkg::QEXT_W'(prp_pkg::RATE_MSEC_MAX)) ?
            prp_pkg::MSEC_W'(prp_pkg::RATE_MSEC_MAX) : prp_pkg::MSEC_W'(q_ext);
    ivl_wins = !fin.dl && (quot < prp_pkg::MSEC_W'(fin.interval));
    delay    = ivl_wins ? prp_pkg::MSEC_W'(fin.interval) : quot;
    offset   = delay;
    if (!fin.active && !fin.dl && offset < prp_pkg::MSEC_W'(prp_pkg::IDLE_WAIT_MS)) begin
      offset = prp_pkg::MSEC_W'(prp_pkg::IDLE_WAIT_MS);
    end
    done_d = v_q[DW-1];
    if (fin.local_client) begin
      next_d       = fin.now - prp_pkg::TIME_W'(1);
      msec_d       = '0;
      delayed_d    = 1'b0;
      flag_valid_d = 1'b0;
    end else begin
      next_d       = fin.now + prp_pkg::TIME_W'(offset);
      msec_d       = delay;
      delayed_d    = !ivl_wins;
      flag_valid_d = 1'b1;
    end
  end

  logic                        done_q;
  logic [prp_pkg::TIME_W-1:0]  next_q;
  logic [prp_pkg::MSEC_W-1:0]  msec_q;
  logic                        delayed_q, flag_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_q <= 1'b0;
    end else begin
      v_q    <= {v_q[DW-2:0], pop_o};
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DW; i++) begin
      st_q[i] <= st_d[i];
    end
    next_q       <= next_d;
    msec_q       <= msec_d;
    delayed_q    <= delayed_d;
    flag_valid_q <= flag_valid_d;
  end

  assign done_o             = done_q;
  assign next_send_time_o   = next_q;
  assign rate_msec_o        = msec_q;
  assign rate_delayed_o     = delayed_q;
  assign delay_flag_valid_o = flag_valid_q;

endmodule

// ===== rtl/core/packet_rate_pacer_unit.sv =====
// Packet rate pacer: for each message sent to a client, works out the
// earliest time the next snapshot may go to that client.
//
// Channels:
//   Command in  - start_i with the message fields; a transaction is taken at
//                 a rising edge with start_i high and busy_o low.
//   Result out  - done_o strobes for one cycle with next_send_time_o,
//                 rate_msec_o, rate_delayed_o and delay_flag_valid_o. The
//                 receiver cannot stall; results are never held off.
//   Config      - cfg_we_i / cfg_idx_i / cfg_data_i: index 0 max_rate,
//                 1 download_max_rate, 2 lan_force_rate. Write-only.
// Throughput: one transaction per cycle; busy_o stays low in steady use.
// From start to done, a transaction passes the front register, the queue,
//   one pipelined restoring divider stage per quotient bit of the 21-bit
//   dividend, and then the result register.
// Results leave in the order transactions were taken.
// Reset: clears config registers to 0 and drops everything in flight.
module packet_rate_pacer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [prp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [prp_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [prp_pkg::SIZE_W-1:0]     message_size_i,
  input  logic [prp_pkg::TIME_W-1:0]     current_time_i,
  input  logic [prp_pkg::RATE_W-1:0]     client_rate_i,
  input  logic [prp_pkg::IVL_W-1:0]      snapshot_interval_i,
  input  logic                           downloading_i,
  input  logic                           client_active_i,
  input  logic                           is_loopback_i,
  input  logic                           is_lan_i,
  output logic                           done_o,
  output logic [prp_pkg::TIME_W-1:0]     next_send_time_o,
  output logic [prp_pkg::MSEC_W-1:0]     rate_msec_o,
  output logic                           rate_delayed_o,
  output logic                           delay_flag_valid_o
);

  prp_pkg::item_t  f_item, q_head;
  logic            q_push, q_full;
  logic            q_empty, q_pop;

  // Front: config registers, classification, dividend/divisor prep
  prp_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .start_i,
    .busy_o,
    .message_size_i,
    .current_time_i,
    .client_rate_i,
    .snapshot_interval_i,
    .downloading_i,
    .client_active_i,
    .is_loopback_i,
    .is_lan_i,
    .q_full_i (q_full),
    .push_o   (q_push),
    .item_o   (f_item)
  );

  // Short queue decoupling front from the divider pipeline
  prp_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // Back: pipelined divide and delay finishing
  prp_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i (q_empty),
    .head_i    (q_head),
    .pop_o     (q_pop),
    .done_o,
    .next_send_time_o,
    .rate_msec_o,
    .rate_delayed_o,
    .delay_flag_valid_o
  );

endmodule

// ===== rtl/core/prp_checker.sv =====
module prp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           done_o,
  input logic [prp_pkg::MSEC_W-1:0]     rate_msec_o,
  input logic                           rate_delayed_o,
  input logic                           delay_flag_valid_o
);

  // Every taken transaction produces a result after the fixed latency
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(prp_pkg::LATENCY) done_o)
    else $error("taken transaction produced no result");

  // No result without a transaction taken the fixed latency earlier
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o && rst_ni, prp_pkg::LATENCY))
    else $error("result without matching transaction");

  // Local clients report zero delay and a clear flag
  a_local_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !delay_flag_valid_o) |-> (rate_msec_o == '0 && !rate_delayed_o))
    else $error("local client result carries a delay");

  // When the interval won, the delay is the 16-bit interval
  a_interval_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && delay_flag_valid_o && !rate_delayed_o) |->
      (rate_msec_o[prp_pkg::MSEC_W-1:prp_pkg::IVL_W] == '0))
    else $error("interval-set delay exceeds interval width");

endmodule

bind packet_rate_pacer_unit prp_checker u_prp_checker (.*);
